[rtl/core/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// Newton square root package
// Shared widths, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  localparam int ROOT_W    = 24;
  localparam int TOL_W     = 16;
  localparam int LIMIT_W   = 6;
  localparam int STEPS_W   = 6;

  // Derived datapath widths.
  localparam int DIV_W     = VALUE_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT     = 1'b1;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic update;
    logic conv_wr;
    logic conv_val;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic res_below;
    logic at_limit;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/newton_square_root_unit.sv]
// ----------------------------------------------------------------------------
// Newton square root unit
// Fixed-point square root of the magnitude of a signed Q16.16 value by
// Newton iteration, with a tolerance test and a step limit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i / in_stall_o value_i (signed Q16.16)
//   output    out        out_valid_o/out_stall_i root_o, converged_o, steps_used_o
//   config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// The next input is taken in the cycle after a result is written; each item runs N
// Newton steps, where N is at most the limit.
// Each step squares the guess, tests the residual, runs the bit-serial divider for the
// 48-bit quotient and then updates the guess.
// Reset idles the controller, clears the result valid flag and sets the configuration (7, 32).
// A held-off result waits in the output register; the next item is taken meanwhile.
//
`default_nettype none

module newton_square_root_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [nsr_pkg::VALUE_W-1:0] value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [nsr_pkg::ROOT_W-1:0]              root_o,
  output logic                                    converged_o,
  output logic [nsr_pkg::STEPS_W-1:0]             steps_used_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nsr_pkg::CFG_W-1:0]          cfg_wdata_i
);

  // Commands from the controller and status from the datapath.
  nsr_pkg::cmd_t   cmd;
  nsr_pkg::sts_t   sts;
  nsr_pkg::state_e state;

  // The controller walks each item through square, test, divide and update.
  nsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // The datapath owns all arithmetic, the configuration and the result register.
  nsr_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .root_o       (root_o),
    .converged_o  (converged_o),
    .steps_used_o (steps_used_o)
  );

  // The divider only runs while the controller waits for it.
  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> (state == nsr_pkg::ST_DIV))
    else $error("divider busy outside the divide state");

  // A zero root only comes from a zero input, which converges at once.
  a_zero_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (root_o == '0)) |-> (converged_o && (steps_used_o == '0)))
    else $error("zero root reported with steps or without convergence");

  // After a transfer in, the block is busy with that item.
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice without finishing an item");

  // A result is written only when the output register can take it.
  a_finish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("result written over a waiting result");

endmodule

`default_nettype wire

[rtl/core/nsr_div.sv]
// ----------------------------------------------------------------------------
// Newton square root divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [nsr_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [nsr_pkg::VALUE_W-1:0] divisor_i,
  output logic                             busy_o,
  output logic [nsr_pkg::DIV_W-1:0]        quotient_o
);

  logic                            busy_q, busy_d;
  logic [nsr_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [nsr_pkg::VALUE_W-1:0]     rem_q, rem_d;
  logic [nsr_pkg::DIV_W-1:0]       quo_q, quo_d;
  logic [nsr_pkg::VALUE_W-1:0]     dvs_q, dvs_d;
  logic [nsr_pkg::VALUE_W:0]       rem_sh;
  logic [nsr_pkg::VALUE_W:0]       rem_sub;
  logic                            ge;

  // The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    rem_sh  = {rem_q, quo_q[nsr_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nsr_pkg::DIV_CNT_W'(nsr_pkg::DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[nsr_pkg::VALUE_W-1:0] : rem_sh[nsr_pkg::VALUE_W-1:0];
      quo_d = {quo_q[nsr_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == nsr_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/core/nsr_dpath.sv]
// ----------------------------------------------------------------------------
// Newton square root datapath
// Holds the operand, guess, step count, configuration and result register,
// and carries out the squaring, residual test and Newton update.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nsr_pkg::cmd_t                 cmd_i,
  output nsr_pkg::sts_t                      sts_o,
  input  wire logic signed [nsr_pkg::VALUE_W-1:0] value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nsr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [nsr_pkg::ROOT_W-1:0]         root_o,
  output logic                               converged_o,
  output logic [nsr_pkg::STEPS_W-1:0]        steps_used_o
);

  logic [nsr_pkg::TOL_W-1:0]   tol_q;
  logic [nsr_pkg::LIMIT_W-1:0] lim_q;

  logic [nsr_pkg::VALUE_W-1:0] a_q, a_d;
  logic [nsr_pkg::VALUE_W-1:0] g_q, g_d;
  logic [nsr_pkg::STEPS_W-1:0] steps_q, steps_d;
  logic [nsr_pkg::PROD_W-1:0]  prod_q;
  logic                        conv_q;

  logic                        out_valid_q;
  logic [nsr_pkg::ROOT_W-1:0]  root_q;
  logic                        out_conv_q;
  logic [nsr_pkg::STEPS_W-1:0] out_steps_q;

  logic [nsr_pkg::VALUE_W-1:0] mag;
  logic [nsr_pkg::DIV_W-1:0]   dividend;
  logic [nsr_pkg::VALUE_W-1:0] divisor;
  logic [nsr_pkg::DIV_W-1:0]   quotient;
  logic                        div_busy;
  logic [nsr_pkg::DIV_W:0]     g_sum;
  logic [nsr_pkg::SQ_W-1:0]    sq;
  logic [nsr_pkg::SQ_W-1:0]    a_ext;
  logic [nsr_pkg::SQ_W-1:0]    resid;
  logic [nsr_pkg::ROOT_W-1:0]  root_sat;
  logic                        out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= nsr_pkg::TOL_RESET;
      lim_q <= nsr_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nsr_pkg::CFG_IDX_TOLERANCE: tol_q <= cfg_wdata_i[nsr_pkg::TOL_W-1:0];
        nsr_pkg::CFG_IDX_LIMIT:     lim_q <= cfg_wdata_i[nsr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude of a two's complement value; the most negative code maps to 2^31.
  assign mag = value_i[nsr_pkg::VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  assign dividend = {a_q, {nsr_pkg::FRAC_BITS{1'b0}}};
  assign divisor  = (g_q == '0) ? nsr_pkg::VALUE_W'(1) : g_q;

  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Newton update g = (g + q) / 2; the guess stays within 32 bits.
  assign g_sum = {{(nsr_pkg::DIV_W - nsr_pkg::VALUE_W + 1){1'b0}}, g_q}
               + {1'b0, quotient};

  always_comb begin
    a_d     = a_q;
    g_d     = g_q;
    steps_d = steps_q;
    if (cmd_i.load) begin
      a_d     = mag;
      g_d     = mag;
      steps_d = '0;
    end else if (cmd_i.update) begin
      g_d     = g_sum[nsr_pkg::VALUE_W:1];
      steps_d = steps_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    g_q     <= g_d;
    steps_q <= steps_d;
    if (cmd_i.mul) begin
      prod_q <= g_q * g_q;
    end
    if (cmd_i.conv_wr) begin
      conv_q <= cmd_i.conv_val;
    end
  end

  // Residual |a - g*g / 2^FRAC_BITS| against the tolerance.
  assign sq    = prod_q[nsr_pkg::PROD_W-1:nsr_pkg::FRAC_BITS];
  assign a_ext = nsr_pkg::SQ_W'(a_q);
  assign resid = (a_ext > sq) ? (a_ext - sq) : (sq - a_ext);

  assign root_sat = (|g_q[nsr_pkg::VALUE_W-1:nsr_pkg::ROOT_W]) ? '1
                                                               : g_q[nsr_pkg::ROOT_W-1:0];

  // Result register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      root_q      <= root_sat;
      out_conv_q  <= conv_q;
      out_steps_q <= steps_q;
    end
  end

  always_comb begin
    sts_o.a_zero    = (a_q == '0);
    sts_o.res_below = (resid < nsr_pkg::SQ_W'(tol_q));
    sts_o.at_limit  = (steps_q >= lim_q);
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign converged_o  = out_conv_q;
  assign steps_used_o = out_steps_q;

endmodule

`default_nettype wire

[rtl/core/nsr_ctrl.sv]
// ----------------------------------------------------------------------------
// Newton square root controller
// Sequences squaring, residual test, division and update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire nsr_pkg::sts_t   sts_i,
  output nsr_pkg::cmd_t        cmd_o,
  output nsr_pkg::state_e      state_o
);

  nsr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      nsr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = nsr_pkg::ST_MUL;
      end
      nsr_pkg::ST_MUL: begin
        state_d = nsr_pkg::ST_CHECK;
      end
      nsr_pkg::ST_CHECK: begin
        if (sts_i.a_zero || sts_i.res_below || sts_i.at_limit) begin
          state_d = nsr_pkg::ST_FINISH;
        end else begin
          state_d = nsr_pkg::ST_DIV;
        end
      end
      nsr_pkg::ST_DIV: begin
        if (!sts_i.div_busy) state_d = nsr_pkg::ST_UPDATE;
      end
      nsr_pkg::ST_UPDATE: begin
        state_d = nsr_pkg::ST_MUL;
      end
      nsr_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = nsr_pkg::ST_IDLE;
      end
      default: begin
        state_d = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      nsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      nsr_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      nsr_pkg::ST_CHECK: begin
        if (sts_i.a_zero || sts_i.res_below) begin
          cmd_o.conv_wr  = 1'b1;
          cmd_o.conv_val = 1'b1;
        end else if (sts_i.at_limit) begin
          cmd_o.conv_wr  = 1'b1;
          cmd_o.conv_val = 1'b0;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      nsr_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      nsr_pkg::ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: ;
    endcase
  end

  assign state_o = state_q;

endmodule

`default_nettype wire
